[rtl/fit_placement_allocator_unit_assert.svh]
// Assertion macros shared by the allocator modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FIT_PLACEMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_PLACEMENT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FPA_ASSERT(lbl, prop, msg)
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/fpa_pkg.sv]
package fpa_pkg;

    // Storage geometry
    localparam int BLOCK_COUNT = 16;
    localparam int SIZE_BITS   = 16;
    localparam int IDX_BITS    = $clog2(BLOCK_COUNT);
    localparam int CNT_BITS    = $clog2(BLOCK_COUNT + 1);

    // Fixed port widths
    localparam int BLK_BITS     = 4;
    localparam int AMT_BITS     = 16;
    localparam int BIU_BITS     = 5;
    localparam int STRAT_BITS   = 2;
    localparam int CFG_BITS     = 5;
    localparam int CFG_IDX_BITS = 1;

    // Common compare widths
    localparam int NW  = (CNT_BITS > BIU_BITS) ? CNT_BITS : BIU_BITS;
    localparam int LDW = (CNT_BITS > BLK_BITS) ? CNT_BITS : BLK_BITS;

    localparam logic [BIU_BITS-1:0] BIU_RESET = BIU_BITS'(16);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_STRATEGY      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_IN_USE = CFG_IDX_BITS'(1);

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic [STRAT_BITS-1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_NEXT  = 2'd1,
        STRAT_BEST  = 2'd2,
        STRAT_WORST = 2'd3
    } strategy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic load;
        logic decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic empty;
    } ctrl_stat_t;

endpackage

[rtl/fpa_ctrl.sv]
`include "fit_placement_allocator_unit_assert.svh"

module fpa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               command,
    input  fpa_pkg::ctrl_stat_t stat,
    output fpa_pkg::ctrl_cmd_t  cmd,
    output logic               busy
);

    fpa_pkg::state_t state_reg;
    fpa_pkg::state_t state_next;
    logic [3:0]      cmd_vec;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through load, scan and decide
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (command == fpa_pkg::CMD_ALLOC)
                    begin
                        state_next = stat.empty ? fpa_pkg::ST_DECIDE : fpa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fpa_pkg::ST_LOAD;
                    end
                end
            end
            fpa_pkg::ST_LOAD:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
            fpa_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = fpa_pkg::ST_DECIDE;
                end
            end
            fpa_pkg::ST_DECIDE:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            fpa_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            fpa_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            fpa_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign cmd_vec = cmd;

    `FPA_ASSERT(a_cmd_onehot, $onehot0(cmd_vec), "more than one datapath command active")
    `FPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `FPA_ASSERT(a_busy_drop, $fell(busy) |-> ($past(state_reg) == fpa_pkg::ST_DECIDE || $past(state_reg) == fpa_pkg::ST_LOAD), "busy dropped before a result was formed")

endmodule

[rtl/fpa_datapath.sv]
`include "fit_placement_allocator_unit_assert.svh"

module fpa_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [fpa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fpa_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic [fpa_pkg::BLK_BITS-1:0]         block_index,
    input  logic [fpa_pkg::AMT_BITS-1:0]         amount,
    input  fpa_pkg::ctrl_cmd_t                   cmd,
    output fpa_pkg::ctrl_stat_t                  stat,
    output logic                                 done,
    output logic                                 granted,
    output logic [fpa_pkg::BLK_BITS-1:0]         chosen_block,
    output logic [fpa_pkg::AMT_BITS-1:0]         left_over
);

    // Configuration and persistent state
    fpa_pkg::strategy_t                 strategy_reg;
    logic [fpa_pkg::BIU_BITS-1:0]       biu_reg;
    logic [fpa_pkg::SIZE_BITS-1:0]      cap_reg [fpa_pkg::BLOCK_COUNT];
    logic [fpa_pkg::IDX_BITS-1:0]       rover_reg;

    // Per-item working registers
    logic [fpa_pkg::BLK_BITS-1:0]       idx_reg;
    logic [fpa_pkg::SIZE_BITS-1:0]      req_reg;
    logic [fpa_pkg::IDX_BITS-1:0]       pos_reg;
    logic [fpa_pkg::CNT_BITS-1:0]       cnt_reg;
    logic                               found_reg;
    logic [fpa_pkg::IDX_BITS-1:0]       pick_reg;
    logic [fpa_pkg::SIZE_BITS-1:0]      keep_reg;

    // Result registers
    logic                               done_reg;
    logic                               granted_reg;
    logic [fpa_pkg::BLK_BITS-1:0]       chosen_reg;
    logic [fpa_pkg::AMT_BITS-1:0]       left_reg;

    logic [fpa_pkg::NW-1:0]             biu_w;
    logic [fpa_pkg::NW-1:0]             n_full;
    logic [fpa_pkg::CNT_BITS-1:0]       n_cnt;
    logic                               rover_in;
    logic [fpa_pkg::IDX_BITS-1:0]       start_pos;
    logic [fpa_pkg::CNT_BITS-1:0]       pos_inc;
    logic [fpa_pkg::IDX_BITS-1:0]       pos_wrap;
    logic [fpa_pkg::SIZE_BITS-1:0]      cur;
    logic                               fits;
    logic [fpa_pkg::SIZE_BITS-1:0]      diff;
    logic                               first_kind;
    logic                               take;
    logic                               load_ok;

    // Saturate the searched block count
    assign biu_w  = fpa_pkg::NW'(biu_reg);
    assign n_full = (biu_w > fpa_pkg::NW'(fpa_pkg::BLOCK_COUNT)) ?
                    fpa_pkg::NW'(fpa_pkg::BLOCK_COUNT) : biu_w;
    assign n_cnt  = n_full[fpa_pkg::CNT_BITS-1:0];

    // Next fit starts at the rover when it lies inside the searched range
    assign rover_in  = fpa_pkg::CNT_BITS'(rover_reg) < n_cnt;
    assign start_pos = (strategy_reg == fpa_pkg::STRAT_NEXT && rover_in) ?
                       rover_reg : '0;

    // Step the scan position, wrapping at the searched count
    assign pos_inc  = fpa_pkg::CNT_BITS'(pos_reg) + fpa_pkg::CNT_BITS'(1);
    assign pos_wrap = (pos_inc >= n_cnt) ? '0 : pos_inc[fpa_pkg::IDX_BITS-1:0];

    // Test the current block against the request
    assign cur        = cap_reg[pos_reg];
    assign fits       = cur >= req_reg;
    assign diff       = cur - req_reg;
    assign first_kind = (strategy_reg == fpa_pkg::STRAT_FIRST) ||
                        (strategy_reg == fpa_pkg::STRAT_NEXT);
    assign take       = fits &&
                        (!found_reg ||
                         (strategy_reg == fpa_pkg::STRAT_BEST  && diff < keep_reg) ||
                         (strategy_reg == fpa_pkg::STRAT_WORST && diff > keep_reg));

    assign stat.scan_done = (cnt_reg == fpa_pkg::CNT_BITS'(1)) || (fits && first_kind);
    assign stat.empty     = (n_cnt == '0);

    assign load_ok = fpa_pkg::LDW'(idx_reg) < fpa_pkg::LDW'(fpa_pkg::BLOCK_COUNT);

    // Hold configuration, capacities, rover and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= fpa_pkg::STRAT_FIRST;
            biu_reg      <= fpa_pkg::BIU_RESET;
            rover_reg    <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < fpa_pkg::BLOCK_COUNT; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fpa_pkg::REG_STRATEGY:
                    begin
                        strategy_reg <= fpa_pkg::strategy_t'(cfg_data[fpa_pkg::STRAT_BITS-1:0]);
                    end
                    fpa_pkg::REG_BLOCKS_IN_USE:
                    begin
                        biu_reg <= cfg_data[fpa_pkg::BIU_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan && take)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.load && load_ok)
            begin
                cap_reg[idx_reg[fpa_pkg::IDX_BITS-1:0]] <= req_reg;
            end

            if (cmd.decide && found_reg)
            begin
                cap_reg[pick_reg] <= keep_reg;
                if (strategy_reg == fpa_pkg::STRAT_NEXT)
                begin
                    rover_reg <= pick_reg;
                end
            end

            done_reg <= cmd.load || cmd.decide;
        end
    end

    // Latch the beat, walk the blocks, form the result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= block_index;
            req_reg <= fpa_pkg::SIZE_BITS'(amount);
            pos_reg <= start_pos;
            cnt_reg <= n_cnt;
        end

        if (cmd.scan)
        begin
            pos_reg <= pos_wrap;
            cnt_reg <= cnt_reg - fpa_pkg::CNT_BITS'(1);
            if (take)
            begin
                pick_reg <= pos_reg;
                keep_reg <= diff;
            end
        end

        if (cmd.load)
        begin
            granted_reg <= load_ok;
            chosen_reg  <= load_ok ? idx_reg : '0;
            left_reg    <= load_ok ? fpa_pkg::AMT_BITS'(req_reg) : '0;
        end

        if (cmd.decide)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? fpa_pkg::BLK_BITS'(pick_reg) : '0;
            left_reg    <= found_reg ? fpa_pkg::AMT_BITS'(keep_reg) : '0;
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign chosen_block = chosen_reg;
    assign left_over    = left_reg;

    `FPA_ASSERT(a_done_source,
                done_reg |-> ($past(cmd.load) || $past(cmd.decide)),
                "result strobe without a load or decide cycle")
    `FPA_ASSERT(a_refused_zero,
                done_reg && !granted_reg |-> (chosen_reg == '0 && left_reg == '0),
                "refused beat carries a block or capacity")
    `FPA_ASSERT(a_scan_count,
                cmd.scan |-> (cnt_reg != '0),
                "scan running with no blocks left")
    `FPA_ASSERT(a_keep_match,
                (cmd.scan || cmd.decide) && found_reg |->
                    (cap_reg[pick_reg] >= req_reg && (cap_reg[pick_reg] - req_reg) == keep_reg),
                "kept leftover does not match the picked block")

endmodule

[rtl/fit_placement_allocator_unit.sv]
// Load: the accepted beat, the write state, then the result strobe.
// Allocate: the scan state checks blocks in turn (up to blocks in use, at most 16), the decide
// state, then the strobe.
// A new beat is taken only while busy is low, once the last result is formed; the receiver cannot stall.
// Reset (rst_n low, asynchronous) zeroes all capacities and the rover, selects first fit
// and sets sixteen blocks in use.
module fit_placement_allocator_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [fpa_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                             start,
    input  logic                             command,
    input  logic [fpa_pkg::BLK_BITS-1:0]     block_index,
    input  logic [fpa_pkg::AMT_BITS-1:0]     amount,
    output logic                             busy,
    output logic                             done,
    output logic                             granted,
    output logic [fpa_pkg::BLK_BITS-1:0]     chosen_block,
    output logic [fpa_pkg::AMT_BITS-1:0]     left_over
);

    fpa_pkg::ctrl_cmd_t  cmd;
    fpa_pkg::ctrl_stat_t stat;

    // Sequence the item
    fpa_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Hold capacities and search them
    fpa_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .block_index  (block_index),
        .amount       (amount),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .granted      (granted),
        .chosen_block (chosen_block),
        .left_over    (left_over)
    );

endmodule
